[rtl/grh_pkg.sv]
// Shared widths and codes for the horizontal grid-line ray intersection block.
package grh_pkg;

  localparam int CELL_W   = 6;
  localparam int COORD_W  = 20;
  localparam int INVT_W   = 32;
  localparam int OUT_W    = 32;
  localparam int CFG_W    = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Item kinds carried in the action field.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  // Register index as seen on paddr[2].
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

[rtl/grh_in_if.sv]
// Request channel into the ray block: map writes and ray casts.
interface grh_in_if import grh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [CELL_W-1:0]        cell_row;
  logic [CELL_W-1:0]        cell_col;
  logic                     cell_is_wall;
  logic [COORD_W-1:0]       player_x;
  logic [COORD_W-1:0]       player_y;
  logic                     facing_up;
  logic signed [INVT_W-1:0] inv_tangent;

  modport source (
    output valid, action, cell_row, cell_col, cell_is_wall,
           player_x, player_y, facing_up, inv_tangent,
    input  ready
  );
  modport sink (
    input  valid, action, cell_row, cell_col, cell_is_wall,
           player_x, player_y, facing_up, inv_tangent,
    output ready
  );
endinterface

[rtl/grh_out_if.sv]
// Result channel out of the ray block: intercept and wall flag.
interface grh_out_if import grh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] hit_x;
  logic signed [OUT_W-1:0] hit_y;
  logic                    hit_wall;

  modport source (output valid, hit_x, hit_y, hit_wall, input ready);
  modport sink (input valid, hit_x, hit_y, hit_wall, output ready);
endinterface

[rtl/grid_ray_horizontal_hit.sv]
// Ray march along horizontal tile-grid lines against a one-bit wall map.
// After reset the wall map is swept to open, one entry per cycle, over all
// 2**(clog2(MAX_MAP_ROWS)+clog2(MAX_MAP_COLUMNS)) entries (4096 at the defaults), and no
// request is taken during that sweep; register writes are taken as ever. A map write is
// taken only while idle, and the block stays idle after it. A ray runs through a small
// sequencer. Tile indices come from one shared divide by the tile size, done as a
// reciprocal multiply and then a one-step correction. The first grid line is found by
// the row divide, its correction and a row set-up; each tile row that is inspected then
// runs multiply, add, bounds check, column divide and its correction, map read and check,
// and a failed bounds check or a found wall leads to the result hand-off. The result is
// held in an output register, so the next request is taken while it waits.
module grid_ray_horizontal_hit import grh_pkg::*; #(
  parameter int TILE_PIXELS     = 64,
  parameter int MAX_MAP_COLUMNS = 64,
  parameter int MAX_MAP_ROWS    = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  grh_in_if.sink            in_ch,
  grh_out_if.source         out_ch
);

  localparam int TQ    = TILE_PIXELS * 256;
  localparam int TQW   = $clog2(TQ + 1);
  localparam int CAW   = $clog2(MAX_MAP_COLUMNS);
  localparam int RAW   = $clog2(MAX_MAP_ROWS);
  localparam int AW    = RAW + CAW;
  localparam int DEPTH = 1 << AW;
  localparam int RW    = COORD_W + 1 - TQW;
  localparam int QW    = (RW > CAW) ? RW : CAW;
  localparam int DW    = TQW + QW;
  localparam int NW    = DW - 8;
  localparam int RS    = NW + 8;
  localparam int RM    = (1 << RS) / TILE_PIXELS;
  localparam int MW    = NW + RS;
  localparam int YLIM_A = (1 << COORD_W) + TQ;
  localparam int YLIM_B = MAX_MAP_ROWS * TQ;
  localparam int YW    = $clog2(((YLIM_A > YLIM_B) ? YLIM_A : YLIM_B) + 1);
  localparam int DYW   = YW + 1;
  localparam int PW    = DYW + INVT_W;
  localparam int XW    = PW - 15;
  localparam int LXW   = CFG_W + TQW;
  localparam int RGW   = ((RW > 8) ? RW : 8) + 1;
  localparam logic [CFG_W-1:0] COLS_RST = CFG_W'((64 > MAX_MAP_COLUMNS) ? MAX_MAP_COLUMNS : 64);
  localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'((64 > MAX_MAP_ROWS) ? MAX_MAP_ROWS : 64);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_ROWSET = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_XADD   = 4'd5;
  localparam logic [3:0] S_RANGE  = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_CHECK  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_DFIX   = 4'd10;

  logic [3:0]               state;
  logic [AW-1:0]            clr_addr;
  logic [CFG_W-1:0]         cols;
  logic [CFG_W-1:0]         rows;

  logic [COORD_W-1:0]       px;
  logic [COORD_W-1:0]       py;
  logic                     up;
  logic signed [INVT_W-1:0] it_r;
  logic [YW-1:0]            y;
  logic [RGW-1:0]           row;
  logic [LXW-1:0]           lim_x;
  logic signed [PW-1:0]     prod;
  logic signed [XW-1:0]     x;
  logic                     wall_found;

  logic [NW-1:0]            div_n;
  logic [QW-1:0]            div_q;
  logic                     div_col;
  logic [MW-1:0]            div_prod;
  logic [NW-1:0]            div_r;

  logic                     out_valid;
  logic signed [OUT_W-1:0]  hit_x;
  logic signed [OUT_W-1:0]  hit_y;
  logic                     hit_wall;

  logic                     wall_mem [DEPTH];
  logic                     rd_bit;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic                     mem_wdata;
  logic [AW-1:0]            mem_raddr;

  logic                     in_acc;
  logic                     cfg_we;
  logic [8:0]               cfg_val9;
  logic [8:0]               wr_row9;
  logic [8:0]               wr_col9;
  logic                     wr_ok;
  logic signed [DYW-1:0]    dy;
  logic signed [PW-17:0]    prod_sh;
  logic [RGW-1:0]           chk_row;
  logic [RGW-1:0]           row_init;
  logic                     in_bounds;
  logic signed [OUT_W-1:0]  sat_x;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign cfg_val9 = 9'(pwdata[CFG_W-1:0]);
  assign prdata   = (paddr[2] == REG_ROWS) ? APB_DW'(rows) : APB_DW'(cols);

  assign wr_row9  = 9'(in_ch.cell_row);
  assign wr_col9  = 9'(in_ch.cell_col);
  assign wr_ok    = (wr_row9 < 9'(MAX_MAP_ROWS)) && (wr_col9 < 9'(MAX_MAP_COLUMNS));

  assign mem_we    = (state == S_CLEAR) || (in_acc && (in_ch.action == ACT_WRITE) && wr_ok);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr
                                        : {wr_row9[RAW-1:0], wr_col9[CAW-1:0]};
  assign mem_wdata = (state == S_CLEAR) ? 1'b0 : in_ch.cell_is_wall;

  // Facing up, the wall to test sits in the row above the grid line.
  assign chk_row   = up ? (row - RGW'(1)) : row;
  assign mem_raddr = {chk_row[RAW-1:0], div_q[CAW-1:0]};

  // The sub-pixel fraction is dropped first; the estimate is at most one below the true quotient.
  assign div_prod = MW'(div_n) * MW'(RM);
  assign div_r    = div_n - NW'(div_q) * NW'(TILE_PIXELS);
  assign row_init = RGW'(div_q) + (up ? RGW'(0) : RGW'(1));

  assign dy      = $signed({1'b0, y}) - $signed(DYW'(py));
  assign prod_sh = prod[PW-1:16];

  assign in_bounds = (x >= $signed(XW'(TQ))) && (x < $signed(XW'(lim_x)))
                     && (row != '0) && (row < RGW'(rows));

  always_comb begin
    if ((x[XW-1:OUT_W-1] == '0) || (x[XW-1:OUT_W-1] == '1)) begin
      sat_x = x[OUT_W-1:0];
    end else if (x[XW-1]) begin
      sat_x = SAT_NEG;
    end else begin
      sat_x = SAT_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wall_mem[mem_waddr] <= mem_wdata;
    end
    rd_bit <= wall_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= COLS_RST;
      rows <= ROWS_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_COLS) begin
        cols <= (cfg_val9 > 9'(MAX_MAP_COLUMNS)) ? CFG_W'(MAX_MAP_COLUMNS)
                                                  : pwdata[CFG_W-1:0];
      end else begin
        rows <= (cfg_val9 > 9'(MAX_MAP_ROWS)) ? CFG_W'(MAX_MAP_ROWS)
                                               : pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (in_ch.action == ACT_CAST)) begin
            px         <= in_ch.player_x;
            py         <= in_ch.player_y;
            up         <= in_ch.facing_up;
            it_r       <= in_ch.inv_tangent;
            wall_found <= 1'b0;
            div_n      <= NW'(in_ch.player_y[COORD_W-1:8]);
            div_col    <= 1'b0;
            state      <= S_DIV;
          end
        end
        S_DIV: begin
          div_q <= div_prod[RS+QW-1:RS];
          state <= S_DFIX;
        end
        S_DFIX: begin
          if (div_r >= NW'(TILE_PIXELS)) begin
            div_q <= div_q + QW'(1);
          end
          state <= div_col ? S_READ : S_ROWSET;
        end
        S_ROWSET: begin
          // First grid line: the top of the player's tile, or its bottom when facing down.
          y     <= YW'(row_init) * YW'(TQ);
          row   <= row_init;
          lim_x <= LXW'(cols) * LXW'(TQ);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= dy * it_r;
          state <= S_XADD;
        end
        S_XADD: begin
          x     <= $signed(XW'(px)) + XW'(prod_sh);
          state <= S_RANGE;
        end
        S_RANGE: begin
          if (in_bounds) begin
            div_n   <= x[DW-1:8];
            div_col <= 1'b1;
            state   <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_bit) begin
            wall_found <= 1'b1;
            state      <= S_DONE;
          end else begin
            if (up) begin
              y   <= y - YW'(TQ);
              row <= row - RGW'(1);
            end else begin
              y   <= y + YW'(TQ);
              row <= row + RGW'(1);
            end
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            hit_x     <= sat_x;
            hit_y     <= OUT_W'(y);
            hit_wall  <= wall_found;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.hit_x    = hit_x;
  assign out_ch.hit_y    = hit_y;
  assign out_ch.hit_wall = hit_wall;

endmodule

[rtl/grh_checker.sv]
// Port-level checks for the ray block, bound onto its top level.
module grh_checker import grh_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // The map sweep after reset keeps the request side closed.
  a_closed_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken right after reset");

  // A map write never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_action == ACT_WRITE) && !out_valid |=> !out_valid)
    else $error("result appeared after a map write");

  // A taken ray closes the request side while the block works on it.
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_action == ACT_CAST) |=> !in_ready)
    else $error("request side open right after a ray was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

endmodule

bind grid_ray_horizontal_hit grh_checker u_grh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
